@@ src/sacl_pkg.sv @@
`timescale 1ns / 1ps

package sacl_pkg;

    // Default geometry
    localparam int SETS_DEF       = 64;
    localparam int WAYS_DEF       = 4;
    localparam int LINE_SIZE_DEF  = 64;
    localparam int ADDR_BITS_DEF  = 32;

    // Fixed field widths of the ports
    localparam int REQ_W  = 2;
    localparam int ADDR_W = 32;
    localparam int SET_W  = 6;
    localparam int WAY_W  = 2;
    localparam int VTAG_W = 26;

    typedef enum logic [REQ_W-1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_FLUSH = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;    // latch address, read the set's rows
        logic commit;     // write back the set, load the lookup response
        logic load_zero;  // load an all-zero response
        logic clr_valid;  // clear the valid row at the sweep counter
        logic init_rank;  // load initial ranks at the sweep counter
        logic sweep_adv;  // advance the sweep counter
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic sweep_last;
    } sts_t;

endpackage

@@ src/set_assoc_cache_lru_tags_unit.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Handshake             Payload
// request   in   req_valid, req_stall  req_type, addr
// response  out  rsp_valid, rsp_stall  hit, way, set_index, fill_needed,
//                                      fill_block_addr, victim_was_valid, victim_tag
//
// Read/write: the registered row read of the valid, tag and rank RAMs, followed
//   by the compare, LRU update and write-back of that set; no new request is
//   taken until that write-back has loaded the response register.
// Flush: sweeps the valid RAM one set per cycle.
// Reset: clears the valid bits and loads initial ranks of every set, with
//   req_stall high.
// A stalled response holds in its register; one more request is still taken and
//   waits in lookup until the response register frees.

module set_assoc_cache_lru_tags_unit #(
    parameter int SETS       = sacl_pkg::SETS_DEF,
    parameter int WAYS       = sacl_pkg::WAYS_DEF,
    parameter int LINE_SIZE  = sacl_pkg::LINE_SIZE_DEF,
    parameter int ADDR_BITS  = sacl_pkg::ADDR_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [sacl_pkg::REQ_W-1:0]    req_type,
    input  logic [sacl_pkg::ADDR_W-1:0]   addr,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic                          hit,
    output logic [sacl_pkg::WAY_W-1:0]    way,
    output logic [sacl_pkg::SET_W-1:0]    set_index,
    output logic                          fill_needed,
    output logic [sacl_pkg::ADDR_W-1:0]   fill_block_addr,
    output logic                          victim_was_valid,
    output logic [sacl_pkg::VTAG_W-1:0]   victim_tag
);

    sacl_pkg::cmd_t cmd;
    sacl_pkg::sts_t sts;

    sacl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req_type),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    sacl_dpath #(
        .SETS       (SETS),
        .WAYS       (WAYS),
        .LINE_SIZE  (LINE_SIZE),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .addr             (addr),
        .rsp_stall        (rsp_stall),
        .rsp_valid        (rsp_valid),
        .hit              (hit),
        .way              (way),
        .set_index        (set_index),
        .fill_needed      (fill_needed),
        .fill_block_addr  (fill_block_addr),
        .victim_was_valid (victim_was_valid),
        .victim_tag       (victim_tag)
    );

endmodule

@@ src/sacl_ram.sv @@
`timescale 1ns / 1ps

module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/sacl_ctrl.sv @@
`timescale 1ns / 1ps

module sacl_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    input  logic [sacl_pkg::REQ_W-1:0]   req_type,
    output logic                         req_stall,
    input  sacl_pkg::sts_t               sts,
    output sacl_pkg::cmd_t               cmd
);

    typedef enum logic [4:0] {
        ST_INIT   = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_LOOKUP = 5'b00100,
        ST_FLUSH  = 5'b01000,
        ST_ZERO   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            ST_INIT:
            begin
                cmd.clr_valid = 1'b1;
                cmd.init_rank = 1'b1;
                cmd.sweep_adv = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    case (req_type)
                        sacl_pkg::REQ_READ,
                        sacl_pkg::REQ_WRITE:
                        begin
                            cmd.capture = 1'b1;
                            state_next  = ST_LOOKUP;
                        end
                        sacl_pkg::REQ_FLUSH:
                        begin
                            state_next = ST_FLUSH;
                        end
                        sacl_pkg::REQ_NONE:
                        begin
                            state_next = ST_ZERO;
                        end
                        default:
                        begin
                            state_next = ST_ZERO;
                        end
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                // hold until the response register can take the result
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                cmd.clr_valid = 1'b1;
                cmd.sweep_adv = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_ZERO;
                end
            end
            ST_ZERO:
            begin
                if (sts.out_free)
                begin
                    cmd.load_zero = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    a_flush_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && req_type == sacl_pkg::REQ_FLUSH) |=> (state_reg == ST_FLUSH))
        else $error("flush request did not start the valid sweep");

    a_access_looks_up: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall
         && (req_type == sacl_pkg::REQ_READ || req_type == sacl_pkg::REQ_WRITE))
        |=> (state_reg == ST_LOOKUP && !cmd.clr_valid))
        else $error("access request did not move to lookup");

endmodule

@@ src/sacl_dpath.sv @@
`timescale 1ns / 1ps

module sacl_dpath #(
    parameter int SETS       = sacl_pkg::SETS_DEF,
    parameter int WAYS       = sacl_pkg::WAYS_DEF,
    parameter int LINE_SIZE  = sacl_pkg::LINE_SIZE_DEF,
    parameter int ADDR_BITS  = sacl_pkg::ADDR_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sacl_pkg::cmd_t                cmd,
    output sacl_pkg::sts_t                sts,
    input  logic [sacl_pkg::ADDR_W-1:0]   addr,
    input  logic                          rsp_stall,
    output logic                          rsp_valid,
    output logic                          hit,
    output logic [sacl_pkg::WAY_W-1:0]    way,
    output logic [sacl_pkg::SET_W-1:0]    set_index,
    output logic                          fill_needed,
    output logic [sacl_pkg::ADDR_W-1:0]   fill_block_addr,
    output logic                          victim_was_valid,
    output logic [sacl_pkg::VTAG_W-1:0]   victim_tag
);

    localparam int AW     = sacl_pkg::ADDR_W;
    localparam int SW     = sacl_pkg::SET_W;
    localparam int WW     = sacl_pkg::WAY_W;
    localparam int VW     = sacl_pkg::VTAG_W;
    localparam int OB     = $clog2(LINE_SIZE);
    localparam int IB     = $clog2(SETS);
    localparam int WB     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TB_RAW = ADDR_BITS - OB - IB;
    localparam int TW     = (TB_RAW > 0) ? TB_RAW : 1;
    // wide enough that set and tag slices never run past the top
    localparam int XW     = ((ADDR_BITS > AW) ? ADDR_BITS : AW) + OB + IB;

    logic [XW-1:0]      ax_in;
    logic [XW-1:0]      ax_reg;
    logic [IB-1:0]      set_in;
    logic [IB-1:0]      set_reg;
    logic [TW-1:0]      tag_c;
    logic [IB-1:0]      cnt_reg;
    logic [IB-1:0]      cnt_next;

    logic [WAYS-1:0]    vrow;
    logic [WAYS*WB-1:0] rrow;
    logic [WAYS*TW-1:0] trow;
    logic [WAYS-1:0]    vrow_new;
    logic [WAYS*WB-1:0] rrow_new;
    logic [WAYS*TW-1:0] trow_new;
    logic [WAYS*WB-1:0] id_row;

    logic [WAYS-1:0]    match;
    logic               hit_c;
    logic [WB-1:0]      hit_w;
    logic [WB-1:0]      vic_w;
    logic [WB-1:0]      tgt_w;
    logic [WB-1:0]      tgt_rank;
    logic               vic_v;

    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    logic               hit_reg;
    logic [WW-1:0]      way_reg;
    logic [SW-1:0]      set_index_reg;
    logic               fill_needed_reg;
    logic [AW-1:0]      fill_block_addr_reg;
    logic               victim_was_valid_reg;
    logic [VW-1:0]      victim_tag_reg;

    // mask the address to ADDR_BITS, zero above
    generate
        if (ADDR_BITS < AW)
        begin : g_mask
            assign ax_in = XW'(addr[ADDR_BITS-1:0]);
        end
        else
        begin : g_ext
            assign ax_in = XW'(addr);
        end
    endgenerate

    assign set_in  = ax_in[OB +: IB];
    assign set_reg = ax_reg[OB +: IB];
    assign tag_c   = ax_reg[OB + IB +: TW];

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ax_reg <= ax_in;
        end
    end

    assign cnt_next = cmd.sweep_adv ? (cnt_reg + IB'(1)) : cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    sacl_ram #(.WIDTH(WAYS), .DEPTH(SETS)) u_valid_ram (
        .clk     (clk),
        .wr_en   (cmd.clr_valid | cmd.commit),
        .wr_addr (cmd.commit ? set_reg : cnt_reg),
        .wr_data (cmd.commit ? vrow_new : '0),
        .rd_en   (cmd.capture),
        .rd_addr (set_in),
        .rd_data (vrow)
    );

    sacl_ram #(.WIDTH(WAYS * WB), .DEPTH(SETS)) u_rank_ram (
        .clk     (clk),
        .wr_en   (cmd.init_rank | cmd.commit),
        .wr_addr (cmd.commit ? set_reg : cnt_reg),
        .wr_data (cmd.commit ? rrow_new : id_row),
        .rd_en   (cmd.capture),
        .rd_addr (set_in),
        .rd_data (rrow)
    );

    sacl_ram #(.WIDTH(WAYS * TW), .DEPTH(SETS)) u_tag_ram (
        .clk     (clk),
        .wr_en   (cmd.commit & ~hit_c),
        .wr_addr (set_reg),
        .wr_data (trow_new),
        .rd_en   (cmd.capture),
        .rd_addr (set_in),
        .rd_data (trow)
    );

    always_comb
    begin
        logic [WB-1:0] slot;
        match = '0;
        hit_w = '0;
        vic_w = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            match[w] = vrow[w] && (trow[w*TW +: TW] == tag_c);
        end
        // walk down so the lowest way wins
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                hit_w = WB'(w);
            end
            if (rrow[w*WB +: WB] == '0)
            begin
                vic_w = WB'(w);
            end
        end
        hit_c    = |match;
        tgt_w    = hit_c ? hit_w : vic_w;
        tgt_rank = rrow[tgt_w*WB +: WB];
        vic_v    = !hit_c && vrow[vic_w];

        vrow_new        = vrow;
        vrow_new[tgt_w] = 1'b1;
        trow_new        = trow;
        trow_new[tgt_w*TW +: TW] = tag_c;
        for (int i = 0; i < WAYS; i++)
        begin
            slot = rrow[i*WB +: WB];
            id_row[i*WB +: WB] = WB'(i);
            if (WB'(i) == tgt_w)
            begin
                rrow_new[i*WB +: WB] = WB'(WAYS - 1);
            end
            else if (slot > tgt_rank)
            begin
                rrow_new[i*WB +: WB] = slot - WB'(1);
            end
            else
            begin
                rrow_new[i*WB +: WB] = slot;
            end
        end
    end

    assign sts.out_free   = !rsp_valid_reg || !rsp_stall;
    assign sts.sweep_last = (cnt_reg == IB'(SETS - 1));

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (cmd.commit || cmd.load_zero)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hit_reg              <= hit_c;
            way_reg              <= WW'(tgt_w);
            set_index_reg        <= SW'(set_reg);
            fill_needed_reg      <= !hit_c;
            fill_block_addr_reg  <= {ax_reg[AW-1:OB], {OB{1'b0}}};
            victim_was_valid_reg <= vic_v;
            victim_tag_reg       <= vic_v ? VW'(trow[vic_w*TW +: TW]) : '0;
        end
        else if (cmd.load_zero)
        begin
            hit_reg              <= 1'b0;
            way_reg              <= '0;
            set_index_reg        <= '0;
            fill_needed_reg      <= 1'b0;
            fill_block_addr_reg  <= '0;
            victim_was_valid_reg <= 1'b0;
            victim_tag_reg       <= '0;
        end
    end

    assign rsp_valid        = rsp_valid_reg;
    assign hit              = hit_reg;
    assign way              = way_reg;
    assign set_index        = set_index_reg;
    assign fill_needed      = fill_needed_reg;
    assign fill_block_addr  = fill_block_addr_reg;
    assign victim_was_valid = victim_was_valid_reg;
    assign victim_tag       = victim_tag_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit || cmd.load_zero) |-> !(rsp_valid_reg && rsp_stall))
        else $error("response loaded over a stalled response");

    a_victim_is_lru: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !hit_c) |-> (rrow[vic_w*WB +: WB] == '0))
        else $error("refill victim is not the least recently used way");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit || cmd.load_zero) |=> rsp_valid_reg)
        else $error("loaded response not presented");

endmodule
